// ----- rtl/rtps_pkg.sv -----
package rtps_pkg;

    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int EXT_W     = 48;
    localparam int CNT_W     = 32;
    localparam int JIT_W     = 36;
    localparam int DELTA_W   = 18;
    localparam int WIDE_W    = EXT_W + 2;

    localparam logic [SEQ_W-1:0]  DROPOUT_RESET = 16'd3000;
    localparam logic signed [DELTA_W-1:0] SEQ_HALF  = 18'sd32768;
    localparam logic signed [DELTA_W-1:0] SEQ_SPAN  = 18'sd65536;
    localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
    localparam logic [JIT_W-1:0]  JIT_MAX = {JIT_W{1'b1}};
    localparam logic signed [WIDE_W-1:0] EXT_MAX_WIDE =
        {{(WIDE_W-EXT_W+1){1'b0}}, {(EXT_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] EXT_MIN_WIDE =
        {{(WIDE_W-EXT_W+1){1'b1}}, {(EXT_W-1){1'b0}}};

    typedef struct packed {
        logic              seen_first;
        logic [EXT_W-1:0]  highest;
        logic [EXT_W-1:0]  span;
        logic [CNT_W-1:0]  received;
        logic [TIME_W-1:0] prev_transit;
        logic [JIT_W-1:0]  jitter;
    } stats_state_t;

    typedef struct packed {
        logic [EXT_W-1:0] extended_sequence;
        logic [CNT_W-1:0] lost_count;
        logic [JIT_W-1:0] jitter_sixteenths;
    } stats_result_t;

endpackage

// ----- rtl/rtps_in_if.sv -----
interface rtps_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sequence_number;
    logic [31:0] media_timestamp;
    logic [31:0] arrival_time;

    modport source (
        output valid, sequence_number, media_timestamp, arrival_time,
        input  ready
    );
    modport sink (
        input  valid, sequence_number, media_timestamp, arrival_time,
        output ready
    );
endinterface

// ----- rtl/rtps_out_if.sv -----
interface rtps_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] extended_sequence;
    logic [31:0]        lost_count;
    logic [35:0]        jitter_sixteenths;

    modport source (
        output valid, extended_sequence, lost_count, jitter_sixteenths,
        input  ready
    );
    modport sink (
        input  valid, extended_sequence, lost_count, jitter_sixteenths,
        output ready
    );
endinterface

// ----- rtl/rtps_update.sv -----
module rtps_update (
    input  rtps_pkg::stats_state_t          state,
    input  logic [rtps_pkg::SEQ_W-1:0]      seq,
    input  logic [rtps_pkg::TIME_W-1:0]     transit,
    input  logic [rtps_pkg::SEQ_W-1:0]      dropout_limit,
    output rtps_pkg::stats_state_t          state_next,
    output rtps_pkg::stats_result_t         result
);
    import rtps_pkg::*;

    logic signed [DELTA_W-1:0] delta;
    logic signed [WIDE_W-1:0]  ext_wide;
    logic [EXT_W-1:0]          ext;
    logic signed [WIDE_W-1:0]  step_wide;
    logic signed [DELTA_W-1:0] step;
    logic [DELTA_W-1:0]        step_mag;
    logic                      restart;
    logic                      advance;
    logic [CNT_W-1:0]          count_base;
    logic [CNT_W-1:0]          count_new;
    logic [EXT_W-1:0]          span_new;
    logic signed [WIDE_W-1:0]  lost_wide;
    logic [TIME_W-1:0]         transit_diff;
    logic [TIME_W:0]           mag;
    logic [JIT_W:0]            jitter_wide;
    logic [JIT_W-1:0]          jitter_new;

    always_comb
    begin
        delta = $signed({2'b00, seq}) - $signed({2'b00, state.highest[SEQ_W-1:0]});
        if (delta > SEQ_HALF)
        begin
            delta = delta - SEQ_SPAN;
        end
        else if (-delta > SEQ_HALF)
        begin
            delta = delta + SEQ_SPAN;
        end

        ext_wide = $signed({{(WIDE_W-EXT_W){state.highest[EXT_W-1]}}, state.highest})
                 + $signed({{(WIDE_W-DELTA_W){delta[DELTA_W-1]}}, delta});
        if (ext_wide > EXT_MAX_WIDE)
        begin
            ext_wide = EXT_MAX_WIDE;
        end
        else if (ext_wide < EXT_MIN_WIDE)
        begin
            ext_wide = EXT_MIN_WIDE;
        end

        step_wide = ext_wide
                  - $signed({{(WIDE_W-EXT_W){state.highest[EXT_W-1]}}, state.highest});
        step      = step_wide[DELTA_W-1:0];
        step_mag  = step[DELTA_W-1] ? DELTA_W'(-step) : DELTA_W'(step);

        if (!state.seen_first)
        begin
            ext      = {{(EXT_W-SEQ_W){1'b0}}, seq};
            restart  = 1'b1;
            advance  = 1'b0;
        end
        else
        begin
            ext      = ext_wide[EXT_W-1:0];
            restart  = step_mag > {{(DELTA_W-SEQ_W){1'b0}}, dropout_limit};
            advance  = !step[DELTA_W-1] && (step != '0);
        end

        state_next            = state;
        state_next.seen_first = 1'b1;
        if (restart)
        begin
            state_next.highest = ext;
            span_new           = '0;
            count_base         = '0;
        end
        else if (advance)
        begin
            state_next.highest = ext;
            span_new   = state.span + {{(EXT_W-DELTA_W){1'b0}}, step_mag};
            count_base = state.received;
        end
        else
        begin
            span_new   = state.span;
            count_base = state.received;
        end
        count_new = (count_base == CNT_MAX) ? CNT_MAX : count_base + 1'b1;
        state_next.span     = span_new;
        state_next.received = count_new;

        transit_diff = transit - state.prev_transit;
        mag = transit_diff[TIME_W-1]
            ? ({1'b1, {TIME_W{1'b0}}} - {1'b0, transit_diff})
            : {1'b0, transit_diff};
        jitter_wide = {1'b0, state.jitter} - {5'b0, state.jitter[JIT_W-1:4]}
                    + {{(JIT_W-TIME_W){1'b0}}, mag};
        jitter_new  = jitter_wide[JIT_W] ? JIT_MAX : jitter_wide[JIT_W-1:0];
        if (count_new > 1)
        begin
            state_next.jitter = jitter_new;
        end
        state_next.prev_transit = transit;

        lost_wide = $signed({2'b00, span_new}) + WIDE_W'(1)
                  - $signed({{(WIDE_W-CNT_W){1'b0}}, count_new});
        result.extended_sequence = ext;
        if (lost_wide[WIDE_W-1] || (lost_wide == '0))
        begin
            result.lost_count = '0;
        end
        else if (lost_wide[WIDE_W-1:CNT_W] != '0)
        begin
            result.lost_count = CNT_MAX;
        end
        else
        begin
            result.lost_count = lost_wide[CNT_W-1:0];
        end
        result.jitter_sixteenths = state_next.jitter;
    end

endmodule

// ----- rtl/rtp_receive_statistics.sv -----
// RTP receiver statistics: one packet transaction in, one statistics transaction out,
// with a new packet accepted every cycle while stats.ready does not hold back the output. An
// input register holds the sequence number and the transit time, and the result register
// is loaded together with the stream state, so the combinational state update sets the
// rate of one packet per clock. The extended sequence is signed and saturates at 48 bits,
// the lost count floors at zero and saturates at 32 bits, and the jitter is kept in sixteenths of a timestamp tick.
// Write the dropout limit (reset value 3000) only while no packet is in flight.
module rtp_receive_statistics (
    input  logic                       clk,
    input  logic                       rst_n,
    rtps_in_if.sink                    pkt,
    rtps_out_if.source                 stats,
    input  logic                       cfg_write,
    input  logic [rtps_pkg::SEQ_W-1:0] cfg_data
);
    import rtps_pkg::*;

    logic               in_valid_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [TIME_W-1:0]  transit_reg;
    logic               out_valid_reg;
    stats_result_t      result_reg;
    stats_result_t      result_next;
    stats_state_t       state_reg;
    stats_state_t       state_next;
    logic [SEQ_W-1:0]   dropout_limit_reg;
    logic               out_advance;
    logic               in_advance;

    assign out_advance = !out_valid_reg || stats.ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign pkt.ready   = in_advance;

    rtps_update u_update (
        .state         (state_reg),
        .seq           (seq_reg),
        .transit       (transit_reg),
        .dropout_limit (dropout_limit_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= '0;
            dropout_limit_reg <= DROPOUT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                dropout_limit_reg <= cfg_data;
            end
            if (in_advance)
            begin
                in_valid_reg <= pkt.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && pkt.valid)
        begin
            seq_reg     <= pkt.sequence_number;
            transit_reg <= pkt.arrival_time - pkt.media_timestamp;
        end
        if (out_advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign stats.valid             = out_valid_reg;
    assign stats.extended_sequence = $signed(result_reg.extended_sequence);
    assign stats.lost_count        = result_reg.lost_count;
    assign stats.jitter_sixteenths = result_reg.jitter_sixteenths;

endmodule

// ----- dv/rtp_stats_checker.sv -----
`timescale 1ns / 1ps

module rtp_stats_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    rtps_in_if                         pkt,
    rtps_out_if                        stats,
    input  logic                       cfg_write,
    input  logic [rtps_pkg::SEQ_W-1:0] cfg_data,
    output int                         error_count,
    output int                         pending_count,
    output int                         checked_count,
    output int                         restart_count
);
    import rtps_pkg::*;

    localparam longint WINDOW_HALF = 64'sd32768;
    localparam longint WINDOW_SPAN = 64'sd65536;
    localparam longint EXT_CEIL    = 64'sd140737488355327;
    localparam longint EXT_FLOOR   = -EXT_CEIL - 64'sd1;
    localparam int     REPORT_MAX  = 10;

    logic [SEQ_W-1:0]  dropout_limit;
    logic              have_base;
    longint            base_ext;
    longint            top_ext;
    logic [CNT_W-1:0]  rx_count;
    logic [TIME_W-1:0] last_transit;
    logic [JIT_W-1:0]  jitter_acc;

    stats_result_t     expected_stats[$];
    stats_result_t     got_stats;
    stats_result_t     want_stats;

    function automatic stats_result_t predict_stats(input logic [SEQ_W-1:0] seq,
                                                    input logic [TIME_W-1:0] ts,
                                                    input logic [TIME_W-1:0] arr);
        longint            ext;
        longint            jump;
        longint            span;
        logic [TIME_W-1:0] transit;
        logic [TIME_W-1:0] delta;
        longint unsigned   mag;
        longint unsigned   jit_next;
        longint unsigned   lost;
        stats_result_t     res;
        if (!have_base)
        begin
            have_base = 1'b1;
            ext       = longint'({48'd0, seq});
            base_ext  = ext;
            top_ext   = ext;
        end
        else
        begin
            ext = top_ext - longint'(top_ext & 64'hFFFF) + longint'({48'd0, seq});
            if (ext - top_ext > WINDOW_HALF)
                ext = ext - WINDOW_SPAN;
            if (top_ext - ext > WINDOW_HALF)
                ext = ext + WINDOW_SPAN;
            if (ext > EXT_CEIL)
                ext = EXT_CEIL;
            if (ext < EXT_FLOOR)
                ext = EXT_FLOOR;
            jump = ext - top_ext;
            if (jump < 0)
                jump = -jump;
            if (jump > longint'({48'd0, dropout_limit}))
            begin
                base_ext      = ext;
                top_ext       = ext;
                rx_count      = '0;
                restart_count = restart_count + 1;
            end
            else if (ext > top_ext)
            begin
                top_ext = ext;
            end
        end
        if (rx_count != CNT_MAX)
            rx_count = rx_count + 1'b1;

        transit = arr - ts;
        if (rx_count > 1)
        begin
            delta    = transit - last_transit;
            mag      = delta[31] ? (64'h1_0000_0000 - {32'd0, delta}) : {32'd0, delta};
            jit_next = {28'd0, jitter_acc} - {32'd0, jitter_acc[JIT_W-1:4]} + mag;
            if (jit_next > {28'd0, JIT_MAX})
                jit_next = {28'd0, JIT_MAX};
            jitter_acc = jit_next[JIT_W-1:0];
        end
        last_transit = transit;

        span = top_ext - base_ext + 64'sd1;
        if (span > longint'({32'd0, rx_count}))
        begin
            lost = unsigned'(span - longint'({32'd0, rx_count}));
            if (lost > {32'd0, CNT_MAX})
                lost = {32'd0, CNT_MAX};
        end
        else
        begin
            lost = 64'd0;
        end

        res.extended_sequence = ext[EXT_W-1:0];
        res.lost_count        = lost[CNT_W-1:0];
        res.jitter_sixteenths = jitter_acc;
        return res;
    endfunction

    task automatic log_failure(input string what);
        error_count = error_count + 1;
        if (error_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropout_limit = DROPOUT_RESET;
            have_base     = 1'b0;
            base_ext      = 0;
            top_ext       = 0;
            rx_count      = '0;
            last_transit  = '0;
            jitter_acc    = '0;
            expected_stats.delete();
            error_count   = 0;
            pending_count = 0;
            checked_count = 0;
            restart_count = 0;
        end
        else
        begin
            if (cfg_write)
                dropout_limit = cfg_data;

            // compare before queueing: a result never leaves in the cycle its packet enters
            if (stats.valid && stats.ready)
            begin
                got_stats.extended_sequence = stats.extended_sequence;
                got_stats.lost_count        = stats.lost_count;
                got_stats.jitter_sixteenths = stats.jitter_sixteenths;
                if (expected_stats.size() == 0)
                begin
                    log_failure($sformatf("unexpected result ext=%h lost=%h jit=%h",
                                          got_stats.extended_sequence, got_stats.lost_count,
                                          got_stats.jitter_sixteenths));
                end
                else
                begin
                    want_stats    = expected_stats.pop_front();
                    checked_count = checked_count + 1;
                    if (got_stats !== want_stats)
                        log_failure($sformatf(
                            "result %0d expected ext=%h lost=%h jit=%h got ext=%h lost=%h jit=%h",
                            checked_count, want_stats.extended_sequence,
                            want_stats.lost_count, want_stats.jitter_sixteenths,
                            got_stats.extended_sequence, got_stats.lost_count,
                            got_stats.jitter_sixteenths));
                end
            end

            if (pkt.valid && pkt.ready)
                expected_stats.push_back(predict_stats(pkt.sequence_number,
                                                       pkt.media_timestamp,
                                                       pkt.arrival_time));

            pending_count = expected_stats.size();
        end
    end

endmodule

// ----- dv/rtp_receive_statistics_tb.sv -----
`timescale 1ns / 1ps

module rtp_receive_statistics_tb;
    import rtps_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 200;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write;
    logic [SEQ_W-1:0] cfg_data;
    logic             hold_stats = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int sent_count    = 0;
    int error_count;
    int pending_count;
    int checked_count;
    int restart_count;

    logic [SEQ_W-1:0]  stream_seq;
    logic [TIME_W-1:0] stream_ts;
    logic [TIME_W-1:0] stream_transit;

    rtps_in_if  pkt_if ();
    rtps_out_if stats_if ();

    rtp_receive_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt_if),
        .stats     (stats_if),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    rtp_stats_checker stats_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt           (pkt_if),
        .stats         (stats_if),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .restart_count (restart_count)
    );

    always #10 clk = ~clk;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stats_sink
        stats_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            stats_if.ready <= rst_n && !hold_stats && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] ts,
                               input logic [TIME_W-1:0] arr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid           <= 1'b1;
        pkt_if.sequence_number <= seq;
        pkt_if.media_timestamp <= ts;
        pkt_if.arrival_time    <= arr;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // mostly in-order streams with loss, reordering and restarts; some pure noise
    task automatic send_stream_item();
        int                pick;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
        logic [TIME_W-1:0] arr;
        pick = $urandom_range(99);
        if (pick < 78)
        begin
            stream_seq = stream_seq + (($urandom_range(9) == 0) ? 16'($urandom_range(2, 6))
                                                                  : 16'd1);
            stream_ts  = stream_ts + $urandom_range(4000);
            seq        = stream_seq;
            ts         = stream_ts;
            arr        = stream_ts + stream_transit + $urandom_range(300);
        end
        else if (pick < 88)
        begin
            seq = stream_seq - 16'($urandom_range(12));
            ts  = stream_ts - $urandom_range(20000);
            arr = stream_ts + stream_transit + $urandom_range(300);
        end
        else if (pick < 94)
        begin
            stream_seq     = 16'($urandom);
            stream_ts      = $urandom;
            stream_transit = $urandom;
            seq            = stream_seq;
            ts             = stream_ts;
            arr            = stream_ts + stream_transit;
        end
        else
        begin
            seq = 16'($urandom);
            ts  = $urandom;
            arr = $urandom;
        end
        send_packet(seq, ts, arr);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_dropout(input logic [SEQ_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase();
        int k;
        for (k = 0; k < PHASE_ITEMS; k++)
            send_stream_item();
        pkt_if.valid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin : stimulus
        int k;
        pkt_if.valid           <= 1'b0;
        pkt_if.sequence_number <= '0;
        pkt_if.media_timestamp <= '0;
        pkt_if.arrival_time    <= '0;
        cfg_write              <= 1'b0;
        cfg_data               <= '0;
        stream_seq     = 16'($urandom);
        stream_ts      = $urandom;
        stream_transit = $urandom;
        send_idle_pct  = 9;
        recv_idle_pct  = 65;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dropout limit: seed, backward wrap below zero, forward wrap, loss
        send_packet(16'h0001, 32'h0000_0000, 32'h0000_0000);
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_packet(16'h0000, 32'h0000_0010, 32'hFFFF_FFFF);
        send_packet(16'h0004, 32'h0000_0020, 32'h8000_0020);
        send_packet(16'h0003, 32'h0000_0030, 32'h0000_0030);
        send_packet(16'h0003, 32'h1234_5678, 32'h1234_5678);
        send_packet(16'h0BBC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_packet(16'h1775, 32'h8000_0000, 32'h0000_0001);
        send_packet(16'h1776, 32'h8000_0100, 32'h0000_0180);
        pkt_if.valid <= 1'b0;
        wait_idle();

        // zero limit: any jump restarts, a duplicate does not
        write_dropout(16'h0000);
        send_packet(16'h1777, 32'h0000_1000, 32'h0000_2000);
        send_packet(16'h1777, 32'h0000_1000, 32'h0000_2000);
        send_packet(16'h1779, 32'h0000_1100, 32'h0000_2300);
        pkt_if.valid <= 1'b0;
        wait_idle();

        // widest limits: half-window jumps on both sides
        write_dropout(16'hFFFF);
        send_packet(16'h9778, 32'h0000_2000, 32'h0000_2000);
        send_packet(16'h1778, 32'h0000_2100, 32'h0000_2050);
        send_packet(16'h1777, 32'h0000_2200, 32'h0000_2200);
        pkt_if.valid <= 1'b0;
        wait_idle();
        write_dropout(16'h8000);
        send_packet(16'h9777, 32'hFFFF_0000, 32'h0000_0000);
        send_packet(16'h1776, 32'hFFFF_0100, 32'h0000_0200);
        send_packet(16'h1777, 32'hFFFF_0200, 32'h0000_0200);
        pkt_if.valid <= 1'b0;
        wait_idle();

        write_dropout(16'($urandom_range(1, 4000)));
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            send_stream_item();
            if (k == PHASE_ITEMS / 2)
            begin
                pkt_if.valid <= 1'b0;
                wait_idle();
            end
        end
        pkt_if.valid <= 1'b0;
        wait_idle();

        write_dropout(16'd1);
        send_idle_pct = 65;
        recv_idle_pct = 9;
        run_phase();

        write_dropout(16'h8000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_stats <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_stats <= 1'b0;
            end
        join_none
        run_phase();

        $display("Checked %0d statistics results for %0d packets, %0d stream restarts seen.",
                 checked_count, sent_count, restart_count);
        $display("Dropout limits 0, 1, 3000, 32768, 65535 and a random one; %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rtps_pkg.sv
rtl/rtps_in_if.sv
rtl/rtps_out_if.sv
rtl/rtps_update.sv
rtl/rtp_receive_statistics.sv
dv/rtp_stats_checker.sv
dv/rtp_receive_statistics_tb.sv
